/* rtl/idiv_pkg.sv */
// idiv_pkg: shared types and codes for the 64-bit integer divider
// no dependencies; imported by int64_divider
package idiv_pkg;

    localparam int DATA_W = 64;

    // division mode
    localparam logic ACT_UNSIGNED = 1'b0;
    localparam logic ACT_SIGNED   = 1'b1;

    // result status
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_DIV_ZERO = 1'b1;

    typedef struct packed {
        logic              action;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
        logic              status;
    } t_div_rsp;

endpackage

/* rtl/idiv_core.sv */
// idiv_core: radix-2 restoring divide unit, one quotient bit per cycle
// depends on nothing outside this file; instantiated by int64_divider
module idiv_core #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_num,
    input  logic [WIDTH-1:0] i_den,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quo,
    output logic [WIDTH-1:0] o_rem
);

    localparam int CNT_W = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_den;

    logic [WIDTH-1:0] w_shift;
    logic [WIDTH+1:0] w_diff;
    logic             w_take;

    // shift in the next dividend bit, trial subtract with a spare sign bit
    always_comb begin
        w_shift = {r_rem[WIDTH-2:0], r_quo[WIDTH-1]};
        w_diff  = {1'b0, r_rem[WIDTH-1], w_shift} - {2'b00, r_den};
        w_take  = ~w_diff[WIDTH+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_take ? w_diff[WIDTH-1:0] : w_shift;
            r_quo <= {r_quo[WIDTH-2:0], w_take};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

/* rtl/int64_divider.sv */
// int64_divider: signed/unsigned integer divider, quotient and remainder together
// depends on idiv_pkg (types, codes) and idiv_core (shared restoring unit)
//
//  channel   | ports                          | beat marked by
//  ----------+--------------------------------+-------------------------------
//  request   | i_req (action/dividend/divisor)| start high while busy low
//  result    | o_rsp (quotient/remainder/stat)| o_valid high for one cycle
//
// nonzero divisor: after the accept the sequencer passes through S_PREP (take magnitudes
// and start the core), S_RUN (core divides, one bit per cycle, until it finishes) and
// S_POST (sign fixup), then raises the strobe; zero divisor: S_PREP raises it directly
// busy is high from the accept until the result is registered and is already low
// in the strobe cycle, so the next beat can be taken at the edge that ends it
// reset (synchronous, active low) returns the sequencer to idle and drops strobes
// the receiver cannot stall: o_valid is a single-cycle strobe
module int64_divider #(
    parameter int WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  idiv_pkg::t_div_req i_req,
    output logic              busy,
    output logic              o_valid,
    output idiv_pkg::t_div_rsp o_rsp
);

    import idiv_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_RUN,
        S_POST
    } t_state;

    t_state           r_state;
    logic             r_valid;
    t_div_rsp         r_rsp;

    // operand and sign registers
    logic [WIDTH-1:0] r_n;
    logic [WIDTH-1:0] r_d;
    logic             r_signed;
    logic             r_nneg;
    logic             r_dneg;

    // core handshake
    logic             w_core_start;
    logic             w_core_done;
    logic [WIDTH-1:0] w_core_quo;
    logic [WIDTH-1:0] w_core_rem;

    // magnitudes fed to the core
    logic             w_nneg;
    logic             w_dneg;
    logic [WIDTH-1:0] w_na;
    logic [WIDTH-1:0] w_da;
    logic             w_dzero;

    always_comb begin
        w_nneg       = (r_signed == ACT_SIGNED) && r_n[WIDTH-1];
        w_dneg       = (r_signed == ACT_SIGNED) && r_d[WIDTH-1];
        w_na         = w_nneg ? (WIDTH'(0) - r_n) : r_n;
        w_da         = w_dneg ? (WIDTH'(0) - r_d) : r_d;
        w_dzero      = (r_d == '0);
        w_core_start = (r_state == S_PREP) && !w_dzero;
    end

    idiv_core #(
        .WIDTH (WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_core_start),
        .i_num   (w_na),
        .i_den   (w_da),
        .o_done  (w_core_done),
        .o_quo   (w_core_quo),
        .o_rem   (w_core_rem)
    );

    // sequencer with registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    // zero divisor skips the core entirely
                    if (w_dzero) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_core_done) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_signed <= i_req.action;
            r_n      <= i_req.dividend[WIDTH-1:0];
            r_d      <= i_req.divisor[WIDTH-1:0];
        end
        if (r_state == S_PREP) begin
            r_nneg <= w_nneg;
            r_dneg <= w_dneg;
            // divide-by-zero result: quotient zero, dividend handed back
            r_rsp.quotient  <= '0;
            r_rsp.remainder <= DATA_W'(r_n);
            r_rsp.status    <= ST_DIV_ZERO;
        end
        if (r_state == S_POST) begin
            // quotient negated on sign mismatch, remainder follows dividend
            r_rsp.quotient  <= DATA_W'((r_nneg != r_dneg) ? (WIDTH'(0) - w_core_quo)
                                                          : w_core_quo);
            r_rsp.remainder <= DATA_W'(r_nneg ? (WIDTH'(0) - w_core_rem) : w_core_rem);
            r_rsp.status    <= ST_OK;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // result strobe never lasts more than one cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held");

    // an accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accept did not raise busy");

    // the core only finishes while the sequencer waits on it
    a_core_done_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_core_done |-> (r_state == S_RUN))
        else $error("core finished outside run");

    // divide-by-zero results carry a zero quotient
    a_dz_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status == ST_DIV_ZERO) |-> (o_rsp.quotient == '0))
        else $error("nonzero quotient on zero divisor");

    // busy is already low whenever a result is delivered
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result while still busy");

endmodule
